FILE: rtl/core/ffgs_pkg.sv
// Package for the free group search core: widths, reset values, codes.
// No dependencies; imported by the channel interfaces and the core.
`default_nettype none

package ffgs_pkg;

    localparam int NumGroupsDef   = 256;
    localparam int GroupW         = 8;
    localparam int GptW           = 5;
    localparam int CfgIdxW        = 2;
    localparam int CfgDataW       = 8;
    localparam int StepW          = 11;
    localparam int DistW          = 10;
    localparam int CandW          = 12;

    localparam logic [StepW-1:0]  UNBOUNDED_STEPS = 11'd1024;

    localparam logic [GptW-1:0]   GPT_RESET   = 5'd2;
    localparam logic [GroupW-1:0] START_RESET = 8'd36;
    localparam logic [GroupW-1:0] LAST_RESET  = 8'd79;
    localparam logic [GroupW-1:0] FREE_RESET  = 8'd255;

    localparam logic [CfgIdxW-1:0] CFG_GPT   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_START = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_LAST  = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_FREE  = 2'd3;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

endpackage

`default_nettype wire

FILE: rtl/core/ffgs_if.sv
// Request and response channel interfaces of the free group search core.
// Depends on ffgs_pkg.
`default_nettype none

interface ffgs_req_if
    import ffgs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              action;
    logic [GroupW-1:0] group_index;
    logic [GroupW-1:0] entry_value;

    modport source (output valid, output action, output group_index,
                    output entry_value, input ready);
    modport sink   (input valid, input action, input group_index,
                    input entry_value, output ready);
endinterface

interface ffgs_rsp_if
    import ffgs_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              found;
    logic [GroupW-1:0] free_group;

    modport source (output valid, output found, output free_group, input ready);
    modport sink   (input valid, input found, input free_group, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fat_free_group_search_core.sv
// Free group search core: allocation table memory, outward track search.
// Depends on ffgs_pkg and the channel interfaces in ffgs_if.sv.
// Write transaction: result to the output register, or held if it is still full;
// one write accepted per cycle while each result is taken. Search transaction:
// one table read per in-range step; steps = 2*max(last-start, start), or 1024
// when unbounded. Reset: state, valid flags, config to defaults; table not cleared.
`default_nettype none

module fat_free_group_search_core
    import ffgs_pkg::*;
#(
    parameter int NUM_GROUPS = NumGroupsDef
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_wen,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    ffgs_req_if.sink                 req,
    ffgs_rsp_if.source               rsp
);

    localparam int AW = $clog2(NUM_GROUPS);
    localparam logic signed [CandW-1:0] NG_S = CandW'(NUM_GROUPS);

    typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_HOLD} state_t;

    state_t            state_reg, state_next;
    logic [GptW-1:0]   gpt_reg, gpt_next;
    logic [GroupW-1:0] start_reg, start_next;
    logic [GroupW-1:0] last_reg, last_next;
    logic [GroupW-1:0] free_reg, free_next;
    logic [GptW-1:0]   g_reg, g_next;
    logic [StepW-1:0]  step_reg, step_next;
    logic [StepW-1:0]  steps_reg, steps_next;
    logic [GptW-1:0]   j_reg, j_next;
    logic              odd_reg, odd_next;
    logic [DistW-1:0]  dist_reg, dist_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [GroupW-1:0] cand_q_reg, cand_q_next;
    logic              res_found_reg, res_found_next;
    logic [GroupW-1:0] res_group_reg, res_group_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_found_reg, out_found_next;
    logic [GroupW-1:0] out_group_reg, out_group_next;

    logic [GroupW-1:0] mem [NUM_GROUPS];
    logic [GroupW-1:0] mem_q;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;

    logic signed [CandW-1:0] cand;
    logic signed [CandW-1:0] start_s;
    logic signed [CandW-1:0] last_s;
    logic signed [CandW-1:0] dist_s;
    logic signed [CandW-1:0] j_s;
    logic              in_range;
    logic              slot_free;
    logic              hit;
    logic              fin;
    logic              fin_found;
    logic [GroupW-1:0] fin_group;
    logic [GroupW-1:0] span;
    logic [GroupW-1:0] m_val;

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.found      = out_found_reg;
    assign rsp.free_group = out_group_reg;

    assign wr_en = req.valid && req.ready && (req.action == ACT_WRITE)
                   && ({1'b0, req.group_index} < 9'(NUM_GROUPS));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[req.group_index[AW-1:0]] <= req.entry_value;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_comb
    begin
        start_s  = $signed({4'b0, start_reg});
        last_s   = $signed({4'b0, last_reg});
        dist_s   = $signed({2'b0, dist_reg});
        j_s      = $signed({7'b0, j_reg});
        cand     = odd_reg ? (start_s + dist_s + j_s) : (start_s - dist_s + j_s);
        in_range = !cand[CandW-1] && (cand <= last_s) && (cand < NG_S);
        slot_free = !out_valid_reg || rsp.ready;
        hit       = rd_valid_reg && (mem_q == free_reg);
        span      = last_reg - start_reg;
        m_val     = (span < start_reg) ? start_reg : span;

        state_next     = state_reg;
        gpt_next       = gpt_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        free_next      = free_reg;
        g_next         = g_reg;
        step_next      = step_reg;
        steps_next     = steps_reg;
        j_next         = j_reg;
        odd_next       = odd_reg;
        dist_next      = dist_reg;
        rd_valid_next  = rd_valid_reg;
        cand_q_next    = cand_q_reg;
        res_found_next = res_found_reg;
        res_group_next = res_group_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_found_next = out_found_reg;
        out_group_next = out_group_reg;
        rd_en          = 1'b0;
        rd_addr        = cand[AW-1:0];
        fin            = 1'b0;
        fin_found      = 1'b0;
        fin_group      = '0;

        if (cfg_wen)
        begin
            case (cfg_index)
                CFG_GPT:   gpt_next   = cfg_data[GptW-1:0];
                CFG_START: start_next = cfg_data;
                CFG_LAST:  last_next  = cfg_data;
                CFG_FREE:  free_next  = cfg_data;
                default:   ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.action == ACT_WRITE)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        g_next        = (gpt_reg == '0) ? GptW'(1) : gpt_reg;
                        step_next     = '0;
                        j_next        = '0;
                        odd_next      = 1'b0;
                        dist_next     = DistW'((gpt_reg == '0) ? GptW'(1) : gpt_reg);
                        rd_valid_next = 1'b0;
                        if ((last_reg >= start_reg) && (m_val != '0))
                        begin
                            steps_next = {2'b0, m_val, 1'b0};
                        end
                        else
                        begin
                            steps_next = UNBOUNDED_STEPS;
                        end
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (hit)
                begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_group = cand_q_reg;
                end
                else if ((step_reg == steps_reg) && !rd_valid_reg)
                begin
                    fin = 1'b1;
                end
                else
                begin
                    rd_valid_next = 1'b0;
                    if (step_reg < steps_reg)
                    begin
                        step_next = step_reg + 1'b1;
                        if (in_range)
                        begin
                            rd_en         = 1'b1;
                            rd_valid_next = 1'b1;
                            cand_q_next   = cand[GroupW-1:0];
                        end
                        if (j_reg == g_reg - 1'b1)
                        begin
                            j_next   = '0;
                            odd_next = !odd_reg;
                            if (odd_reg)
                            begin
                                dist_next = dist_reg + DistW'(g_reg);
                            end
                        end
                        else
                        begin
                            j_next = j_reg + 1'b1;
                        end
                    end
                end
            end
            ST_HOLD:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_group_next = res_group_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            rd_valid_next = 1'b0;
            if (slot_free)
            begin
                out_valid_next = 1'b1;
                out_found_next = fin_found;
                out_group_next = fin_group;
                state_next     = ST_IDLE;
            end
            else
            begin
                res_found_next = fin_found;
                res_group_next = fin_group;
                state_next     = ST_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gpt_reg       <= GPT_RESET;
            start_reg     <= START_RESET;
            last_reg      <= LAST_RESET;
            free_reg      <= FREE_RESET;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gpt_reg       <= gpt_next;
            start_reg     <= start_next;
            last_reg      <= last_next;
            free_reg      <= free_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg         <= g_next;
        step_reg      <= step_next;
        steps_reg     <= steps_next;
        j_reg         <= j_next;
        odd_reg       <= odd_next;
        dist_reg      <= dist_next;
        cand_q_reg    <= cand_q_next;
        res_found_reg <= res_found_next;
        res_group_reg <= res_group_next;
        out_found_reg <= out_found_next;
        out_group_reg <= out_group_next;
    end

    a_notfound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |-> (rsp.free_group == '0))
        else $error("not-found result carries a nonzero group");

    a_found_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.found) |-> (rsp.free_group <= last_reg))
        else $error("found group beyond last group");

    a_read_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == ST_SEARCH))
        else $error("pending table read outside a search");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEARCH) |-> (step_reg <= steps_reg))
        else $error("search step beyond its bound");

endmodule

`default_nettype wire

FILE: tb/sv/fat_free_group_search_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fat_free_group_search_core: table writes and outward searches
// checked against a predictor of the search order. Depends on ffgs_pkg, ffgs_if.sv and the core.

module fat_free_group_search_core_tb
    import ffgs_pkg::*;
;
    localparam int NUM_GROUPS     = NumGroupsDef;
    localparam int IDLE_PCT       = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 12000;
    localparam int RANDOM_PHASES  = 13;
    localparam int PHASE_ITEMS    = 70;

    typedef struct packed {
        logic              action;
        logic [GroupW-1:0] group_index;
        logic [GroupW-1:0] entry_value;
    } request_t;

    typedef struct packed {
        logic              found;
        logic [GroupW-1:0] free_group;
    } grant_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b1;
    logic                cfg_wen   = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data  = '0;

    ffgs_req_if req_ch ();
    ffgs_rsp_if rsp_ch ();

    fat_free_group_search_core #(
        .NUM_GROUPS (NUM_GROUPS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predictor copy of the registers and the allocation table
    logic [GptW-1:0]   gpt_cfg   = GPT_RESET;
    logic [GroupW-1:0] start_cfg = START_RESET;
    logic [GroupW-1:0] last_cfg  = LAST_RESET;
    logic [GroupW-1:0] free_cfg  = FREE_RESET;
    logic [GroupW-1:0] alloc_mem [NUM_GROUPS];

    request_t request_q [$];
    grant_t   grant_q [$];
    request_t offered;
    grant_t   got_grant;
    grant_t   want_grant;

    int   items_queued  = 0;
    int   results_seen  = 0;
    int   mismatches    = 0;
    int   hold_requests = 0;
    int   holds_served  = 0;
    int   hold_left     = 0;
    int   quiet_cycles  = 0;
    logic steady        = 1'b0;

    always #2ns clk = ~clk;

    function automatic grant_t find_free_group();
        grant_t hit;
        int     per_track;
        int     steps;
        int     span;
        int     step;
        int     reach;
        int     num;
        per_track = (gpt_cfg == '0) ? 1 : int'(gpt_cfg);
        steps = int'(UNBOUNDED_STEPS);
        if (last_cfg >= start_cfg)
        begin
            span = int'(last_cfg) - int'(start_cfg);
            if (span < int'(start_cfg))
                span = int'(start_cfg);
            if (span != 0)
                steps = 2 * span;
        end
        hit = '0;
        for (step = 0; step < steps && !hit.found; step++)
        begin
            reach = ((step / per_track) / 2 + 1) * per_track;
            if (((step / per_track) % 2) == 0)
                num = int'(start_cfg) - reach + step % per_track;
            else
                num = int'(start_cfg) + reach + step % per_track;
            if (num >= 0 && num <= int'(last_cfg) && num < NUM_GROUPS)
            begin
                if (alloc_mem[num] == free_cfg)
                begin
                    hit.found      = 1'b1;
                    hit.free_group = num[GroupW-1:0];
                end
            end
        end
        return hit;
    endfunction

    task automatic flag_error(input string what, input int got, input int want);
        $display("ERROR %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.action      <= ACT_WRITE;
            req_ch.group_index <= '0;
            req_ch.entry_value <= '0;
            offered = '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                if (offered.action == ACT_WRITE)
                begin
                    alloc_mem[offered.group_index] = offered.entry_value;
                    grant_q.push_back('0);
                end
                else
                begin
                    grant_q.push_back(find_free_group());
                end
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_q.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    offered = request_q.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.action      <= offered.action;
                    req_ch.group_index <= offered.group_index;
                    req_ch.entry_value <= offered.entry_value;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                results_seen <= results_seen + 1;
                got_grant.found      = rsp_ch.found;
                got_grant.free_group = rsp_ch.free_group;
                if (grant_q.size() == 0)
                begin
                    flag_error("response with no request outstanding, free_group",
                               got_grant.free_group, 0);
                end
                else
                begin
                    want_grant = grant_q.pop_front();
                    if (got_grant.found !== want_grant.found)
                        flag_error("found", got_grant.found, want_grant.found);
                    if (got_grant.free_group !== want_grant.free_group)
                        flag_error("free_group", got_grant.free_group, want_grant.free_group);
                end
            end
            if (holds_served != hold_requests)
            begin
                holds_served <= holds_served + 1;
                hold_left    <= HOLD_CYCLES;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_write(input int idx, input int val);
        request_q.push_back('{ACT_WRITE, idx[GroupW-1:0], val[GroupW-1:0]});
        items_queued++;
    endtask

    task automatic push_search();
        request_q.push_back('{ACT_SEARCH, GroupW'($urandom), GroupW'($urandom)});
        items_queued++;
    endtask

    task automatic drain();
        while (results_seen != items_queued)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_config(input int gpt, input int start, input int last, input int free);
        drain();
        write_reg(CFG_GPT, {3'($urandom_range(0, 7)), gpt[GptW-1:0]});
        write_reg(CFG_START, start[GroupW-1:0]);
        write_reg(CFG_LAST, last[GroupW-1:0]);
        write_reg(CFG_FREE, free[GroupW-1:0]);
        cfg_wen   <= 1'b0;
        gpt_cfg   = gpt[GptW-1:0];
        start_cfg = start[GroupW-1:0];
        last_cfg  = last[GroupW-1:0];
        free_cfg  = free[GroupW-1:0];
    endtask

    initial
    begin : stimulus
        int phase;
        int n;
        int pick;
        int gpt;
        int start;
        int last;
        int free;

        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole table with used entries before any search
        for (n = 0; n < NUM_GROUPS; n++)
            push_write(n, $urandom_range(0, 254));

        push_search();
        push_write(40, 255);
        push_search();
        push_write(36, 255);
        push_search();
        push_write(35, 255);
        push_search();

        set_config(0, 0, 255, 255);
        push_search();
        push_write(255, 0);

        set_config(31, 255, 255, 0);
        push_search();
        push_write(224, 0);
        push_search();

        set_config(16, 255, 0, 255);
        push_search();
        push_write(0, 255);
        push_search();

        set_config(1, 0, 0, 255);
        push_search();

        set_config(16, 128, 200, 255);
        push_search();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                gpt = (pick < 7) ? 0 : (pick < 13) ? 1 : (pick < 19) ? 16 : 31;
            else
                gpt = $urandom_range(1, 16);
            pick  = $urandom_range(0, 99);
            start = (pick < 20) ? 0 : (pick < 30) ? 255 : $urandom_range(0, 255);
            pick  = $urandom_range(0, 99);
            last  = (pick < 20) ? 255 : (pick < 30) ? 0 : $urandom_range(0, 255);
            pick  = $urandom_range(0, 99);
            free  = (pick < 10) ? 0 : (pick < 20) ? 255 : $urandom_range(0, 255);
            set_config(gpt, start, last, free);

            steady <= (phase == 3);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 45)
                    push_search();
                else if ($urandom_range(0, 99) < 30)
                    push_write($urandom_range(0, 255), free);
                else
                    push_write($urandom_range(0, 255), $urandom_range(0, 255));
            end
            // hold the response side off while requests keep coming
            if (phase == 7)
                hold_requests <= hold_requests + 1;
        end

        drain();
        steady <= 1'b0;
        repeat (16) @(posedge clk);
        if (mismatches == 0 && grant_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ffgs_pkg.sv
rtl/core/ffgs_if.sv
rtl/core/fat_free_group_search_core.sv
tb/sv/fat_free_group_search_core_tb.sv
